// ----- rtl/core/pidc_pkg.sv -----
// Shared definitions for the clamped PID controller: register map, fixed
// widths, divide-by-1000 constants, stage enable struct and clamp helpers.
// No dependencies.
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned AW = 5;

  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_LO  = 3'd3,
    REG_OUT_HI  = 3'd4,
    REG_INT_LO  = 3'd5,
    REG_INT_HI  = 3'd6
  } pidc_reg_t;

  localparam logic signed [DW-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DW-1:0] S32_MIN = 32'sh8000_0000;

  // Magnitudes at or above 1000 * 2^31 give a quotient outside signed 32 bits.
  localparam logic [63:0] QSAT_LIM = 64'd2147483648000;
  // round-down of 2^32 * 512 / 1000, applied to the magnitude shifted right by 9
  localparam logic [31:0] RECIP_K = 32'd2199023255;
  localparam logic [11:0] DIV_K   = 12'd1000;
  localparam logic [11:0] DIV_K2  = 12'd2000;

  typedef struct packed {
    logic mul;
    logic est;
    logic fix;
    logic term;
  } pidc_en_t;

  function automatic logic signed [DW-1:0] sat_s32(input logic signed [33:0] v);
    logic signed [DW-1:0] res;
    if (v > 34'(S32_MAX)) res = S32_MAX;
    else if (v < 34'(S32_MIN)) res = S32_MIN;
    else res = v[DW-1:0];
    return res;
  endfunction

  // with inverted limits, a value below low gives low and any other value gives high
  function automatic logic signed [DW-1:0] lim32(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi);
    logic signed [DW-1:0] res;
    if (v < lo) res = lo;
    else if (v > hi) res = hi;
    else res = v;
    return res;
  endfunction

endpackage

// ----- rtl/core/pidc_term.sv -----
// One PID term: |gain| * |operand|, divide by 1000 toward zero, saturate to
// signed 32 bits. Four pipeline stages, loaded by enables from the top level.
// Depends on pidc_pkg.
`timescale 1ns / 1ps

module pidc_term (
  input  logic                           clk,
  input  pidc_pkg::pidc_en_t             en,
  input  logic [pidc_pkg::DW-1:0]        a_mag,
  input  logic [pidc_pkg::DW-1:0]        b_mag,
  input  logic                           neg,
  output logic signed [pidc_pkg::DW-1:0] term
);
  import pidc_pkg::*;

  logic [63:0]          prod_r;
  logic                 neg_mul_r;
  logic [63:0]          scaled;
  logic [DW-1:0]        est_r;
  logic [11:0]          mlo_r;
  logic                 over_est_r;
  logic                 neg_est_r;
  logic [11:0]          rem;
  logic [DW-1:0]        q_nxt;
  logic [DW-1:0]        q_r;
  logic                 over_fix_r;
  logic                 neg_fix_r;
  logic signed [DW-1:0] term_nxt;
  logic signed [DW-1:0] term_r;

  // estimate is at most two below the true quotient
  assign scaled = 64'(prod_r[40:9]) * 64'(RECIP_K);
  assign rem    = 12'(mlo_r - 12'(est_r[11:0] * DIV_K));

  always_comb begin
    if (rem >= DIV_K2) q_nxt = est_r + 32'd2;
    else if (rem >= DIV_K) q_nxt = est_r + 32'd1;
    else q_nxt = est_r;
  end

  always_comb begin
    if (over_fix_r) term_nxt = neg_fix_r ? S32_MIN : S32_MAX;
    else if (neg_fix_r) term_nxt = $signed(32'(-q_r));
    else term_nxt = $signed(q_r);
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod_r    <= 64'(a_mag) * 64'(b_mag);
      neg_mul_r <= neg;
    end
    if (en.est) begin
      est_r      <= scaled[63:32];
      mlo_r      <= prod_r[11:0];
      over_est_r <= (prod_r >= QSAT_LIM);
      neg_est_r  <= neg_mul_r;
    end
    if (en.fix) begin
      q_r        <= q_nxt;
      over_fix_r <= over_est_r;
      neg_fix_r  <= neg_est_r;
    end
    if (en.term) begin
      term_r <= term_nxt;
    end
  end

  assign term = term_r;

endmodule

// ----- rtl/core/pid_controller_clamped_unit.sv -----
// Top level of the clamped PID controller: stream channels, APB register
// file, error and integral state, and the ten-stage datapath.
// Depends on pidc_pkg and pidc_term.
`timescale 1ns / 1ps

// Usage
//   Input beat: in_tuser[0] is the command (0 update, 1 clear), in_tdata holds
//   target in bits 31:0 and measured in bits 63:32. An update beat yields one
//   result beat whose out_tdata is the clamped drive value; a clear beat zeroes
//   the integral and the previous error and yields no result.
//   Throughput: one beat per cycle while out_tready is high; the previous-error
//   update and the integral add, saturate and clamp are the feedback paths,
//   and each closes within one stage. Each of the three terms uses one 32x32
//   product and one 32x32 reciprocal multiply in its own stage.
//   Stall: with out_tready low, the pipeline keeps accepting until all nine
//   stages and the output register are full (ten beats), then drops in_tready.
//   Reset (rst_n low, synchronous): pipeline empty, integral and previous
//   error zero, gains zero, limits at the full signed 32-bit range.
//   Registers (APB, byte address 4*i): gain_p, gain_i, gain_d, output_low,
//   output_high, integral_low, integral_high. Writing an integral limit also
//   clamps the stored integral. Write registers only while the block is idle.

module pid_controller_clamped_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // [31:0] target, [63:32] measured
  input  logic [0:0]                  in_tuser,   // [0] cmd
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pidc_pkg::DW-1:0]     out_tdata,  // [31:0] drive
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pidc_pkg::AW-1:0]     cfg_paddr,
  input  logic [pidc_pkg::DW-1:0]     cfg_pwdata,
  output logic [pidc_pkg::DW-1:0]     cfg_prdata,
  output logic                        cfg_pready
);
  import pidc_pkg::*;

  localparam int ST_IN   = 0;
  localparam int ST_ERR  = 1;
  localparam int ST_ABS  = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_EST  = 4;
  localparam int ST_FIX  = 5;
  localparam int ST_TERM = 6;
  localparam int ST_INT  = 7;
  localparam int ST_SUM  = 8;
  localparam int ST_OUT  = 9;
  localparam int NSTG    = 9;

  // configuration
  logic signed [DW-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [DW-1:0]        gp_mag_r, gi_mag_r, gd_mag_r;
  logic                 gp_neg_r, gi_neg_r, gd_neg_r;
  logic signed [DW-1:0] out_lo_r, out_hi_r, int_lo_r, int_hi_r;
  logic                 cfg_wr;
  pidc_reg_t            cfg_idx;
  logic [DW-1:0]        wr_mag;

  // pipeline control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] cmd_r;
  logic [NSTG:0]   rdy;
  logic [NSTG:0]   en;
  pidc_en_t        term_en;

  // datapath
  logic signed [DW-1:0] tgt1_r, meas1_r;
  logic signed [DW-1:0] err2_r, prev2_r, last_err_r;
  logic signed [DW-1:0] err_nxt;
  logic [DW-1:0]        errmag3_r, diffmag3_r;
  logic                 errneg3_r, diffneg3_r;
  logic signed [32:0]   diff_fw, diff_bw;
  logic signed [DW-1:0] p_term, i_term, d_term;
  logic signed [DW-1:0] p8_r, d8_r, acc_r;
  logic signed [DW-1:0] acc_nxt;
  logic signed [DW-1:0] sum9_r;
  logic [DW-1:0]        out_data_r;
  logic                 out_valid_r;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = pidc_reg_t'(cfg_paddr[AW-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_mag     = cfg_pwdata[DW-1] ? 32'(-cfg_pwdata) : cfg_pwdata;

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_P: cfg_prdata = gain_p_r;
      REG_GAIN_I: cfg_prdata = gain_i_r;
      REG_GAIN_D: cfg_prdata = gain_d_r;
      REG_OUT_LO: cfg_prdata = out_lo_r;
      REG_OUT_HI: cfg_prdata = out_hi_r;
      REG_INT_LO: cfg_prdata = int_lo_r;
      REG_INT_HI: cfg_prdata = int_hi_r;
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      gp_mag_r <= '0;
      gi_mag_r <= '0;
      gd_mag_r <= '0;
      gp_neg_r <= 1'b0;
      gi_neg_r <= 1'b0;
      gd_neg_r <= 1'b0;
      out_lo_r <= S32_MIN;
      out_hi_r <= S32_MAX;
      int_lo_r <= S32_MIN;
      int_hi_r <= S32_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_P: begin
          gain_p_r <= $signed(cfg_pwdata);
          gp_mag_r <= wr_mag;
          gp_neg_r <= cfg_pwdata[DW-1];
        end
        REG_GAIN_I: begin
          gain_i_r <= $signed(cfg_pwdata);
          gi_mag_r <= wr_mag;
          gi_neg_r <= cfg_pwdata[DW-1];
        end
        REG_GAIN_D: begin
          gain_d_r <= $signed(cfg_pwdata);
          gd_mag_r <= wr_mag;
          gd_neg_r <= cfg_pwdata[DW-1];
        end
        REG_OUT_LO: out_lo_r <= $signed(cfg_pwdata);
        REG_OUT_HI: out_hi_r <= $signed(cfg_pwdata);
        REG_INT_LO: int_lo_r <= $signed(cfg_pwdata);
        REG_INT_HI: int_hi_r <= $signed(cfg_pwdata);
        default: ;
      endcase
    end
  end

  // stage k loads when its predecessor holds a beat and it is free or draining
  always_comb begin
    rdy[NSTG] = !out_valid_r || out_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    en[ST_IN] = in_tvalid && rdy[ST_IN];
    for (int k = 1; k <= NSTG; k++) begin
      en[k] = v_r[k-1] && rdy[k];
    end
  end

  assign in_tready    = rdy[ST_IN];
  assign term_en.mul  = en[ST_MUL];
  assign term_en.est  = en[ST_EST];
  assign term_en.fix  = en[ST_FIX];
  assign term_en.term = en[ST_TERM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        v_r[k] <= en[k] || (v_r[k] && !rdy[k+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_IN]) cmd_r[ST_IN] <= in_tuser[0];
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) cmd_r[k] <= cmd_r[k-1];
    end
  end

  // error and previous error
  assign err_nxt = sat_s32(34'(tgt1_r) - 34'(meas1_r));

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      tgt1_r  <= $signed(in_tdata[31:0]);
      meas1_r <= $signed(in_tdata[63:32]);
    end
    if (en[ST_ERR]) begin
      err2_r  <= err_nxt;
      prev2_r <= last_err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
    end else if (en[ST_ERR]) begin
      last_err_r <= cmd_r[ST_IN] ? '0 : err_nxt;
    end
  end

  // magnitudes and signs ahead of the multipliers
  assign diff_fw = 33'(err2_r) - 33'(prev2_r);
  assign diff_bw = 33'(prev2_r) - 33'(err2_r);

  always_ff @(posedge clk) begin
    if (en[ST_ABS]) begin
      errneg3_r  <= err2_r[DW-1];
      errmag3_r  <= err2_r[DW-1] ? 32'(-err2_r) : err2_r;
      diffneg3_r <= diff_fw[32];
      diffmag3_r <= diff_fw[32] ? diff_bw[31:0] : diff_fw[31:0];
    end
  end

  pidc_term u_term_p (
    .clk   (clk),
    .en    (term_en),
    .a_mag (gp_mag_r),
    .b_mag (errmag3_r),
    .neg   (gp_neg_r ^ errneg3_r),
    .term  (p_term)
  );

  pidc_term u_term_i (
    .clk   (clk),
    .en    (term_en),
    .a_mag (gi_mag_r),
    .b_mag (errmag3_r),
    .neg   (gi_neg_r ^ errneg3_r),
    .term  (i_term)
  );

  pidc_term u_term_d (
    .clk   (clk),
    .en    (term_en),
    .a_mag (gd_mag_r),
    .b_mag (diffmag3_r),
    .neg   (gd_neg_r ^ diffneg3_r),
    .term  (d_term)
  );

  // integral accumulate; acc_r stays the value of the beat held in the sum stage
  assign acc_nxt = lim32(sat_s32(34'(acc_r) + 34'(i_term)), int_lo_r, int_hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (en[ST_INT]) begin
      acc_r <= cmd_r[ST_TERM] ? '0 : acc_nxt;
    end else if (cfg_wr && cfg_idx == REG_INT_LO) begin
      acc_r <= lim32(acc_r, $signed(cfg_pwdata), int_hi_r);
    end else if (cfg_wr && cfg_idx == REG_INT_HI) begin
      acc_r <= lim32(acc_r, int_lo_r, $signed(cfg_pwdata));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_INT]) begin
      p8_r <= p_term;
      d8_r <= d_term;
    end
    if (en[ST_SUM]) begin
      sum9_r <= sat_s32(34'(p8_r) + 34'(acc_r) + 34'(d8_r));
    end
    if (en[ST_OUT]) begin
      out_data_r <= lim32(sum9_r, out_lo_r, out_hi_r);
    end
  end

  // drop clear beats at the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en[ST_OUT]) begin
      out_valid_r <= !cmd_r[ST_SUM];
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en[ST_OUT] && cmd_r[ST_SUM]) |=> !out_tvalid)
    else $error("clear beat produced a result");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r && out_tvalid && !out_tready))
    else $error("input blocked while pipeline has room");

  a_integral_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (en[ST_INT] && !cmd_r[ST_TERM] && !cfg_wr && int_lo_r <= int_hi_r) |=>
    (acc_r >= int_lo_r && acc_r <= int_hi_r))
    else $error("integral outside its limits");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (en[ST_OUT] && !cmd_r[ST_SUM] && out_lo_r <= out_hi_r) |=>
    ($signed(out_tdata) >= $past(out_lo_r) && $signed(out_tdata) <= $past(out_hi_r)))
    else $error("drive outside output limits");

endmodule
